>>> rtl/core/byte_stream_fingerprint_hash_core_macros.svh
// Assertion macros shared by the fingerprint hash checker.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef BYTE_STREAM_FINGERPRINT_HASH_CORE_MACROS_SVH
`define BYTE_STREAM_FINGERPRINT_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSFH_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fingerprint hash: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSFH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fingerprint hash: next-cycle check failed");

`endif

>>> rtl/core/bsfh_pkg.sv
// Shared types, constants and the mix round function of the fingerprint hash core.
// Used by every module of the core; depends on nothing.
package bsfh_pkg;

    typedef logic [31:0] word_t;
    // Index 0 is word a, 1 is word b, 2 is word c.
    typedef logic [2:0][31:0] lane_t;

    localparam word_t GOLDEN_WORD   = 32'h9e37_79b9;
    localparam word_t DEFAULT_SEED  = 32'hfd12_deff;
    localparam word_t SECOND_SEED   = 32'h0000_7a63;
    localparam logic [63:0] SMALL_FIX = 64'h130f_9bef_94a0_a928;

    localparam int FIFO_DEPTH = 4;
    localparam logic [3:0] MIX_LAST_ROW = 4'd8;
    localparam logic [3:0] BLOCK_LAST_POS = 4'd11;

    typedef enum logic [1:0] {
        CFG_SEED = 2'd0,
        CFG_WIDE = 2'd1,
        CFG_SIGN = 2'd2
    } cfg_index_t;

    // One unit of work handed from the byte gatherer to the mixer.
    typedef struct packed {
        lane_t       blk_sum;   // bytes of the block, already shifted into place
        logic [31:0] length;    // message length up to and including this block
        logic        mix_block; // the block is full and gets its own mix
        logic        finish;    // the message ends with this transaction
    } job_t;

    // One row of the three-word mix; nine rows make one full mix.
    function automatic lane_t mix_row(lane_t w, logic [3:0] row);
        lane_t r;
        r = w;
        case (row)
            4'd0: r[0] = (w[0] - w[1] - w[2]) ^ (w[2] >> 13);
            4'd1: r[1] = (w[1] - w[2] - w[0]) ^ (w[0] << 8);
            4'd2: r[2] = (w[2] - w[0] - w[1]) ^ (w[1] >> 13);
            4'd3: r[0] = (w[0] - w[1] - w[2]) ^ (w[2] >> 12);
            4'd4: r[1] = (w[1] - w[2] - w[0]) ^ (w[0] << 16);
            4'd5: r[2] = (w[2] - w[0] - w[1]) ^ (w[1] >> 5);
            4'd6: r[0] = (w[0] - w[1] - w[2]) ^ (w[2] >> 3);
            4'd7: r[1] = (w[1] - w[2] - w[0]) ^ (w[0] << 10);
            4'd8: r[2] = (w[2] - w[0] - w[1]) ^ (w[1] >> 15);
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/byte_stream_fingerprint_hash_core.sv
// Top level of the byte stream fingerprint hash core: configuration registers,
// byte gatherer, job queue and mixer. Depends on bsfh_pkg and the three submodules.
//
// Usage:
//   Input queue: drive data_byte, has_byte and end_of_message with push; a byte is
//   taken at each clock edge where push is high and full is low. An item with
//   has_byte and end_of_message both low is dropped. end_of_message closes the
//   message, with or without a byte of its own.
//   Result queue: hash_value is valid while empty is low and is taken with pop.
//   Configuration: cfg_valid/cfg_ready write seed (index 0), wide mode (1) and
//   byte sign extension (2); cfg_ready is always high. Write only while idle.
// Timing:
//   Bytes are taken one per cycle while full is low. Each filled 12-byte block
//   costs the mixer one add step and nine mix rows, two lanes side by side, so
//   long messages stream at one byte per cycle while results are popped. The
//   end of a message costs the mixer the add, the mix and an emit step; when
//   the last byte closes a block, a length step and a second mix come between.
//   The four-entry job queue decouples the two sides.
// Reset clears all message state and restores the register defaults. When the
// result is not popped, the mixer holds in its emit step and full rises once
// the job queue fills.
module byte_stream_fingerprint_hash_core #(
    parameter int FIFO_DEPTH = bsfh_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] hash_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    bsfh_pkg::word_t seed_reg;
    logic            wide_reg;
    logic            sign_reg;

    logic            in_fire;
    logic            fe_job_valid;
    bsfh_pkg::job_t  fe_job;
    logic            q_not_empty;
    bsfh_pkg::job_t  q_job;
    logic            be_job_pop;

    assign cfg_ready = 1'b1;
    assign in_fire   = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= bsfh_pkg::DEFAULT_SEED;
            wide_reg <= 1'b0;
            sign_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bsfh_pkg::CFG_SEED: seed_reg <= cfg_data;
                bsfh_pkg::CFG_WIDE: wide_reg <= cfg_data[0];
                bsfh_pkg::CFG_SIGN: sign_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    bsfh_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .sign_extend    (sign_reg),
        .job_valid      (fe_job_valid),
        .job            (fe_job)
    );

    bsfh_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_job_valid),
        .job_in    (fe_job),
        .pop       (be_job_pop),
        .job_out   (q_job),
        .not_empty (q_not_empty),
        .full      (full)
    );

    bsfh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_not_empty),
        .job        (q_job),
        .job_pop    (be_job_pop),
        .seed       (seed_reg),
        .wide       (wide_reg),
        .pop        (pop),
        .empty      (empty),
        .hash_value (hash_value)
    );

endmodule

>>> rtl/core/bsfh_front.sv
// Byte gatherer: widens each byte, sums it into the current 12-byte block and
// hands a job to the mixer when a block fills or a message ends. Uses bsfh_pkg.
module bsfh_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                end_of_message,
    input  logic                sign_extend,
    output logic                job_valid,
    output bsfh_pkg::job_t      job
);

    bsfh_pkg::lane_t sum_reg;
    bsfh_pkg::lane_t sum_next;
    logic [3:0]      pos_reg;
    logic [31:0]     len_reg;
    logic [31:0]     len_next;
    bsfh_pkg::word_t widened;
    bsfh_pkg::word_t addend;
    logic            closes;

    always_comb
    begin
        widened  = {{24{sign_extend & data_byte[7]}}, data_byte};
        addend   = widened << {pos_reg[1:0], 3'b000};
        sum_next = sum_reg;
        if (has_byte)
        begin
            sum_next[pos_reg[3:2]] = sum_reg[pos_reg[3:2]] + addend;
        end
        len_next  = len_reg + {31'b0, has_byte};
        closes    = has_byte && (pos_reg == bsfh_pkg::BLOCK_LAST_POS);
        job_valid = in_fire && (closes || end_of_message);
        job.blk_sum   = sum_next;
        job.length    = len_next;
        job.mix_block = closes;
        job.finish    = end_of_message;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            pos_reg <= '0;
            len_reg <= '0;
        end
        else if (in_fire)
        begin
            if (job_valid)
            begin
                sum_reg <= '0;
                pos_reg <= '0;
                // A full block mid-message keeps the running length.
                len_reg <= end_of_message ? 32'b0 : len_next;
            end
            else if (has_byte)
            begin
                sum_reg <= sum_next;
                pos_reg <= pos_reg + 4'd1;
                len_reg <= len_next;
            end
        end
    end

endmodule

>>> rtl/core/bsfh_fifo.sv
// Short job queue between the byte gatherer and the mixer.
// Uses the job type from bsfh_pkg.
module bsfh_fifo #(
    parameter int DEPTH = bsfh_pkg::FIFO_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bsfh_pkg::job_t job_in,
    input  logic           pop,
    output bsfh_pkg::job_t job_out,
    output logic           not_empty,
    output logic           full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bsfh_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);
    assign job_out   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/bsfh_back.sv
// Mixer: adds each block into both hash lanes, runs the mix one row per cycle,
// finishes messages and holds the result register. Uses bsfh_pkg.
module bsfh_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  bsfh_pkg::job_t  job,
    output logic            job_pop,
    input  bsfh_pkg::word_t seed,
    input  logic            wide,
    input  logic            pop,
    output logic            empty,
    output logic [63:0]     hash_value
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX,
        S_LEN,
        S_EMIT
    } state_t;

    state_t          state_reg;
    bsfh_pkg::lane_t lane1_reg;
    bsfh_pkg::lane_t lane2_reg;
    logic            fresh_reg;
    logic [3:0]      row_reg;
    logic [31:0]     len_reg;
    logic            fin_reg;
    logic            blk_reg;
    logic            out_valid_reg;
    logic [63:0]     hash_reg;

    bsfh_pkg::lane_t base1;
    bsfh_pkg::lane_t base2;
    bsfh_pkg::lane_t add1;
    bsfh_pkg::lane_t add2;
    bsfh_pkg::word_t len_add;
    logic [63:0]     result;
    logic            out_free;

    assign job_pop    = (state_reg == S_IDLE) && job_valid;
    assign out_free   = !out_valid_reg || pop;
    assign empty      = !out_valid_reg;
    assign hash_value = hash_reg;

    always_comb
    begin
        // Lanes start over from the seeds at the first block of a message.
        base1   = fresh_reg ? {seed, bsfh_pkg::GOLDEN_WORD, bsfh_pkg::GOLDEN_WORD}
                            : lane1_reg;
        base2   = fresh_reg ? {bsfh_pkg::SECOND_SEED, bsfh_pkg::GOLDEN_WORD,
                               bsfh_pkg::GOLDEN_WORD}
                            : lane2_reg;
        // A partial last block takes the length in the same step.
        len_add = (job.finish && !job.mix_block) ? job.length : 32'b0;
        for (int i = 0; i < 3; i++)
        begin
            add1[i] = base1[i] + job.blk_sum[i];
            add2[i] = base2[i] + job.blk_sum[i];
        end
        add1[2] = add1[2] + len_add;
        add2[2] = add2[2] + len_add;

        if (wide)
        begin
            result = {lane1_reg[2], lane2_reg[2]};
            if ((lane1_reg[2] == 32'b0) && (lane2_reg[2][31:1] == 31'b0))
            begin
                result = result ^ bsfh_pkg::SMALL_FIX;
            end
        end
        else
        begin
            result = {32'b0, lane1_reg[2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane1_reg     <= '0;
            lane2_reg     <= '0;
            fresh_reg     <= 1'b1;
            row_reg       <= '0;
            len_reg       <= '0;
            fin_reg       <= 1'b0;
            blk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_reg      <= '0;
        end
        else
        begin
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                hash_reg      <= result;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        lane1_reg <= add1;
                        lane2_reg <= add2;
                        fresh_reg <= 1'b0;
                        row_reg   <= '0;
                        len_reg   <= job.length;
                        fin_reg   <= job.finish;
                        blk_reg   <= job.mix_block;
                        state_reg <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    lane1_reg <= bsfh_pkg::mix_row(lane1_reg, row_reg);
                    lane2_reg <= bsfh_pkg::mix_row(lane2_reg, row_reg);
                    row_reg   <= row_reg + 4'd1;
                    if (row_reg == bsfh_pkg::MIX_LAST_ROW)
                    begin
                        if (fin_reg && blk_reg)
                        begin
                            state_reg <= S_LEN;
                        end
                        else if (fin_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_LEN:
                begin
                    // The message ended on a full block: length, then the final mix.
                    lane1_reg[2] <= lane1_reg[2] + len_reg;
                    lane2_reg[2] <= lane2_reg[2] + len_reg;
                    blk_reg      <= 1'b0;
                    row_reg      <= '0;
                    state_reg    <= S_MIX;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        fresh_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/bsfh_checker.sv
// Port-level checker for the fingerprint hash core, bound to the top level.
// Depends on bsfh_pkg and byte_stream_fingerprint_hash_core_macros.svh.
`include "byte_stream_fingerprint_hash_core_macros.svh"

module bsfh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        end_of_message,
    input logic        empty,
    input logic        pop,
    input logic [63:0] hash_value,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [31:0] cfg_data
);

    logic       wide_reg;
    logic [7:0] pend_reg;
    logic       end_in;
    logic       res_out;

    assign end_in  = push && !full && end_of_message;
    assign res_out = pop && !empty;

    // Shadow of the width mode and a count of messages not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b0;
            pend_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && (cfg_index == bsfh_pkg::CFG_WIDE))
            begin
                wide_reg <= cfg_data[0];
            end
            if (end_in && !res_out)
            begin
                pend_reg <= pend_reg + 8'd1;
            end
            else if (res_out && !end_in)
            begin
                pend_reg <= pend_reg - 8'd1;
            end
        end
    end

    `BSFH_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop,
        !empty && $stable(hash_value))
    `BSFH_ASSERT_IMPLY(a_result_has_message, clk, rst_n, !empty, pend_reg != 8'd0)
    `BSFH_ASSERT_IMPLY(a_narrow_upper_zero, clk, rst_n, !empty && !wide_reg,
        hash_value[63:32] == 32'b0)
    `BSFH_ASSERT_IMPLY(a_wide_never_small, clk, rst_n, !empty && wide_reg,
        (hash_value[63:32] != 32'b0) || (hash_value[31:1] != 31'b0))

endmodule

bind byte_stream_fingerprint_hash_core bsfh_checker u_bsfh_checker (.*);
